// ----- rtl/pidbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidbd_pkg
// Types, constants and saturating helpers shared by the PID controller with
// trapezoidal integrator and band-limited derivative.
// ----------------------------------------------------------------------------
package pidbd_pkg;

  localparam int unsigned DataW   = 32;  // Q16.16 words
  localparam int unsigned TauW    = 31;  // unsigned time constant
  localparam int unsigned PeriodW = 16;  // period in milliseconds
  localparam int unsigned TW      = 23;  // sample period in Q16.16 seconds, at most 4294902
  localparam int unsigned DvdW    = 48;  // dividend and quotient width of the serial divider
  localparam int unsigned CfgIdxW = 3;

  localparam logic [DvdW-1:0]  MsRound  = 48'd500;
  localparam logic [DataW-1:0] MsPerSec = 32'd1000;

  localparam logic signed [DataW-1:0] S32Max = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] S32Min = 32'sh8000_0000;
  localparam logic signed [33:0]      S34Max = 34'sd2147483647;
  localparam logic signed [33:0]      S34Min = -34'sd2147483648;

  localparam logic signed [DataW-1:0] GainPRst    = 32'sd13107;
  localparam logic signed [DataW-1:0] GainIRst    = 32'sd0;
  localparam logic signed [DataW-1:0] GainDRst    = 32'sd65536;
  localparam logic [TauW-1:0]         TauRst      = 31'd1311;
  localparam logic signed [DataW-1:0] OutMinRst   = -32'sd1638400;
  localparam logic signed [DataW-1:0] OutMaxRst   = 32'sd1638400;
  localparam logic signed [DataW-1:0] IntegMinRst = -32'sd327680;
  localparam logic signed [DataW-1:0] IntegMaxRst = 32'sd327680;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P,
    CFG_GAIN_I,
    CFG_GAIN_D,
    CFG_FILTER_TAU,
    CFG_OUT_MIN,
    CFG_OUT_MAX,
    CFG_INTEG_MIN,
    CFG_INTEG_MAX
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SUM,
    ST_CLAMP
  } state_e;

  typedef enum logic [2:0] {
    STP_T,
    STP_P,
    STP_K,
    STP_KS,
    STP_A,
    STP_B,
    STP_D
  } step_e;

  typedef enum logic {
    AR_MUL,
    AR_DIV
  } arith_op_e;

  typedef enum logic [1:0] {
    RND_15,
    RND_16,
    RND_17
  } rnd_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
    rnd_e      rnd;
    logic      neg;
  } arith_cmd_t;

  function automatic logic signed [33:0] sext34(input logic signed [DataW-1:0] x);
    return {{2{x[DataW-1]}}, x};
  endfunction

  function automatic logic signed [DataW-1:0] sat34(input logic signed [33:0] x);
    logic signed [DataW-1:0] r;
    if (x > S34Max) begin
      r = S32Max;
    end else if (x < S34Min) begin
      r = S32Min;
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

  // upper limit tested first; with crossed limits, x above hi gives hi, else lo
  function automatic logic signed [DataW-1:0] clamp32(input logic signed [DataW-1:0] x,
                                                      input logic signed [DataW-1:0] lo,
                                                      input logic signed [DataW-1:0] hi);
    logic signed [DataW-1:0] r;
    if (x > hi) begin
      r = hi;
    end else if (x < lo) begin
      r = lo;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

// ----- rtl/pidbd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidbd_if
// Valid/ready channels of the PID controller: sample words in, drive words out.
// ----------------------------------------------------------------------------
interface pidbd_in_if
  import pidbd_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [DataW-1:0]   sp_angle;
  logic signed [DataW-1:0]   fb_angle;
  logic        [PeriodW-1:0] period_ms;

  modport source (output valid, output sp_angle, output fb_angle,
                  output period_ms, input ready);
  modport sink   (input valid, input sp_angle, input fb_angle,
                  input period_ms, output ready);
endinterface

interface pidbd_out_if
  import pidbd_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// ----- rtl/pidbd_arith.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidbd_arith
// Shared serial arithmetic unit: signed Q16.16 multiply with rounding shift,
// two multiplier bits per cycle, and unsigned restoring divide, one quotient
// bit per cycle. Results are saturated to 32 bits.
// ----------------------------------------------------------------------------
module pidbd_arith
  import pidbd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  arith_cmd_t              cmd_i,
  input  logic signed [DataW-1:0] opa_i,
  input  logic signed [DataW-1:0] opb_i,
  input  logic [DvdW-1:0]         dvd_i,
  input  logic [DataW-1:0]        dvs_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] res_o
);

  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned CntW  = 6;
  localparam logic [DvdW-1:0] MagNegLim = DvdW'(1) << (DataW - 1);
  localparam logic [DvdW-1:0] MagPosLim = MagNegLim - DvdW'(1);

  logic                    busy_q, fin_q, done_q;
  logic [CntW-1:0]         cnt_q;
  arith_op_e               op_q;
  rnd_e                    rnd_q;
  logic                    neg_q;
  // work: product accumulator, or dividend shifting out with quotient shifting in
  logic [ProdW-1:0]        work_q, work_d;
  // x: multiplicand or divisor; y: multiplier digits or partial remainder
  logic [DataW-1:0]        x_q;
  logic [DataW-1:0]        y_q, y_d;
  logic signed [DataW-1:0] res_q;

  logic [DataW-1:0]        opa_mag, opb_mag;
  logic [DataW:0]          rem_sh;
  logic [DataW+1:0]        rem_diff;
  logic [ProdW-1:0]        rnd_sum;
  logic [DvdW-1:0]         mag;
  logic signed [DataW-1:0] sat_res;

  assign opa_mag = opa_i[DataW-1] ? DataW'(-opa_i) : DataW'(opa_i);
  assign opb_mag = opb_i[DataW-1] ? DataW'(-opb_i) : DataW'(opb_i);

  always_comb begin
    work_d   = work_q;
    y_d      = y_q;
    rem_sh   = {y_q, work_q[DvdW-1]};
    rem_diff = {1'b0, rem_sh} - {2'b00, x_q};
    unique case (op_q)
      AR_MUL: begin
        // msb first, radix 4
        work_d = (work_q << 2)
               + (y_q[DataW-1] ? {{(DataW-1){1'b0}}, x_q, 1'b0} : '0)
               + (y_q[DataW-2] ? {{DataW{1'b0}}, x_q} : '0);
        y_d    = y_q << 2;
      end
      AR_DIV: begin
        if (!rem_diff[DataW+1]) begin
          y_d    = rem_diff[DataW-1:0];
          work_d = {work_q[ProdW-1:DvdW], work_q[DvdW-2:0], 1'b1};
        end else begin
          y_d    = rem_sh[DataW-1:0];
          work_d = {work_q[ProdW-1:DvdW], work_q[DvdW-2:0], 1'b0};
        end
      end
    endcase
  end

  // round half away from zero on the magnitude, then saturate with the sign
  always_comb begin
    unique case (rnd_q)
      RND_15:  rnd_sum = (work_q + (ProdW'(1) << 14)) >> 15;
      RND_16:  rnd_sum = (work_q + (ProdW'(1) << 15)) >> 16;
      RND_17:  rnd_sum = (work_q + (ProdW'(1) << 16)) >> 17;
      default: rnd_sum = work_q;
    endcase
    mag = (op_q == AR_MUL) ? rnd_sum[DvdW-1:0] : work_q[DvdW-1:0];
    if (neg_q) begin
      sat_res = (mag > MagNegLim) ? S32Min : signed'(DataW'(0) - mag[DataW-1:0]);
    end else begin
      sat_res = (mag > MagPosLim) ? S32Max : signed'(mag[DataW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= (cmd_i.op == AR_DIV) ? CntW'(DvdW) : CntW'(DataW / 2);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= cmd_i.op;
      rnd_q <= cmd_i.rnd;
      if (cmd_i.op == AR_DIV) begin
        neg_q  <= cmd_i.neg;
        x_q    <= dvs_i;
        y_q    <= '0;
        work_q <= {{(ProdW-DvdW){1'b0}}, dvd_i};
      end else begin
        neg_q  <= opa_i[DataW-1] ^ opb_i[DataW-1];
        x_q    <= opa_mag;
        y_q    <= opb_mag;
        work_q <= '0;
      end
    end else if (busy_q) begin
      work_q <= work_d;
      y_q    <= y_d;
    end
    if (fin_q) begin
      res_q <= sat_res;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- rtl/pid_controller_bandlimited_derivative_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_bandlimited_derivative_unit
// PID controller: Tustin integrator with anti-windup clamp, band-limited
// derivative on the measurement and clamped output, all signed Q16.16.
// ----------------------------------------------------------------------------
// samples: a new sample is accepted only in the idle state, once the previous one is done;
//   the shared serial unit works through two divisions and five multiplies in turn, and the
//   derivative division is skipped when 2*tau+T is zero
// a finished drive word waits in the output register while the next sample is taken
// reset: asynchronous, active low; restores the register defaults and zeroes the filter state
module pid_controller_bandlimited_derivative_unit
  import pidbd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_data_i,
  pidbd_in_if.sink           in_i,
  pidbd_out_if.source        out_o
);

  state_e state_q, state_d;
  step_e  step_q, step_d;
  logic   issued_q, issued_d;

  arith_cmd_t              cmd;
  logic signed [DataW-1:0] opa, opb;
  logic [DvdW-1:0]         dvd;
  logic [DataW-1:0]        dvs;
  logic                    ar_done;
  logic signed [DataW-1:0] ar_res;

  logic in_acc, out_free, den_zero;

  // configuration
  logic signed [DataW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [TauW-1:0]         tau_q;
  logic signed [DataW-1:0] out_min_q, out_max_q, integ_min_q, integ_max_q;

  // controller state
  logic signed [DataW-1:0] integ_q, last_err_q, dflt_q, last_meas_q;

  // per-sample working values
  logic signed [DataW-1:0] e_q, meas_q;
  logic [PeriodW-1:0]      period_q;
  logic [TW-1:0]           t_q;
  logic signed [DataW-1:0] p_q, k_q, s_q, dm_q, c_q, a_q, num_q, d_q, inew_q, y_q;
  logic [DataW-2:0]        den_q;
  logic                    out_valid_q;
  logic signed [DataW-1:0] drive_q;

  logic signed [33:0]      tau2, t34;
  logic signed [DataW-1:0] den_sat;
  logic [DataW-1:0]        num_mag;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign den_zero = (den_q == '0);

  assign tau2    = signed'({2'b00, tau_q, 1'b0});
  assign t34     = signed'({{(34-TW){1'b0}}, t_q});
  assign den_sat = sat34(tau2 + t34);
  assign num_mag = num_q[DataW-1] ? DataW'(-num_q) : DataW'(num_q);

  pidbd_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .opa_i  (opa),
    .opb_i  (opb),
    .dvd_i  (dvd),
    .dvs_i  (dvs),
    .done_o (ar_done),
    .res_o  (ar_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= STP_T;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      issued_q <= issued_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    issued_d = issued_q;
    cmd      = '0;
    opa      = '0;
    opb      = '0;
    dvd      = '0;
    dvs      = '0;

    // operand selection for the current step
    unique case (step_q)
      STP_T: begin
        cmd.op = AR_DIV;
        dvd    = {{(DvdW-PeriodW-16){1'b0}}, period_q, 16'd0} + MsRound;
        dvs    = MsPerSec;
      end
      STP_P: begin
        cmd.op  = AR_MUL;
        cmd.rnd = RND_16;
        opa     = gain_p_q;
        opb     = e_q;
      end
      STP_K: begin
        cmd.op  = AR_MUL;
        cmd.rnd = RND_16;
        opa     = gain_i_q;
        opb     = signed'({{(DataW-TW){1'b0}}, t_q});
      end
      STP_KS: begin
        cmd.op  = AR_MUL;
        cmd.rnd = RND_17;
        opa     = k_q;
        opb     = s_q;
      end
      STP_A: begin
        cmd.op  = AR_MUL;
        cmd.rnd = RND_15;
        opa     = gain_d_q;
        opb     = dm_q;
      end
      STP_B: begin
        cmd.op  = AR_MUL;
        cmd.rnd = RND_16;
        opa     = c_q;
        opb     = dflt_q;
      end
      STP_D: begin
        cmd.op  = AR_DIV;
        cmd.neg = num_q[DataW-1];
        dvd     = {num_mag, 16'd0} + {{(DvdW-DataW+2){1'b0}}, den_q[DataW-2:1]};
        dvs     = {1'b0, den_q};
      end
      default: cmd.op = AR_MUL;
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d  = ST_RUN;
          step_d   = STP_T;
          issued_d = 1'b0;
        end
      end
      ST_RUN: begin
        if (!issued_q) begin
          cmd.start = 1'b1;
          issued_d  = 1'b1;
        end else if (ar_done) begin
          issued_d = 1'b0;
          unique case (step_q)
            STP_T:  step_d = STP_P;
            STP_P:  step_d = STP_K;
            STP_K:  step_d = STP_KS;
            STP_KS: step_d = STP_A;
            STP_A:  step_d = STP_B;
            STP_B: begin
              // zero denominator keeps the previous filtered derivative
              if (den_zero) begin
                state_d = ST_SUM;
              end else begin
                step_d = STP_D;
              end
            end
            STP_D:   state_d = ST_SUM;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SUM:   state_d = ST_CLAMP;
      ST_CLAMP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= GainPRst;
      gain_i_q    <= GainIRst;
      gain_d_q    <= GainDRst;
      tau_q       <= TauRst;
      out_min_q   <= OutMinRst;
      out_max_q   <= OutMaxRst;
      integ_min_q <= IntegMinRst;
      integ_max_q <= IntegMaxRst;
      integ_q     <= '0;
      last_err_q  <= '0;
      dflt_q      <= '0;
      last_meas_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_GAIN_P:     gain_p_q    <= cfg_data_i;
          CFG_GAIN_I:     gain_i_q    <= cfg_data_i;
          CFG_GAIN_D:     gain_d_q    <= cfg_data_i;
          CFG_FILTER_TAU: tau_q       <= cfg_data_i[TauW-1:0];
          CFG_OUT_MIN:    out_min_q   <= cfg_data_i;
          CFG_OUT_MAX:    out_max_q   <= cfg_data_i;
          CFG_INTEG_MIN:  integ_min_q <= cfg_data_i;
          CFG_INTEG_MAX:  integ_max_q <= cfg_data_i;
        endcase
      end
      if (state_q == ST_CLAMP && out_free) begin
        integ_q     <= inew_q;
        dflt_q      <= d_q;
        last_err_q  <= e_q;
        last_meas_q <= meas_q;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_q      <= sat34(sext34(in_i.sp_angle) - sext34(in_i.fb_angle));
      meas_q   <= in_i.fb_angle;
      period_q <= in_i.period_ms;
    end
    if (state_q == ST_RUN && issued_q && ar_done) begin
      unique case (step_q)
        STP_T: begin
          t_q  <= ar_res[TW-1:0];
          s_q  <= sat34(sext34(e_q) + sext34(last_err_q));
          dm_q <= sat34(sext34(meas_q) - sext34(last_meas_q));
        end
        STP_P: begin
          p_q   <= ar_res;
          c_q   <= sat34(tau2 - t34);
          den_q <= den_sat[DataW-2:0];
        end
        STP_K:  k_q <= ar_res;
        STP_KS: inew_q <= clamp32(sat34(sext34(integ_q) + sext34(ar_res)),
                                  integ_min_q, integ_max_q);
        STP_A:  a_q <= ar_res;
        STP_B: begin
          num_q <= sat34(sext34(ar_res) - sext34(a_q));
          d_q   <= dflt_q;
        end
        STP_D:  d_q <= ar_res;
        default: ;
      endcase
    end
    if (state_q == ST_SUM) begin
      y_q <= sat34(sext34(p_q) + sext34(inew_q) + sext34(d_q));
    end
    if (state_q == ST_CLAMP && out_free) begin
      drive_q <= clamp32(y_q, out_min_q, out_max_q);
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.drive = drive_q;

endmodule

// ----- rtl/pidbd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidbd_checker
// Port-level checks on the PID controller's sample and drive channels.
// ----------------------------------------------------------------------------
module pidbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] drive_i
);

  // a stalled drive word is neither dropped nor altered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("drive word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(drive_i))
    else $error("drive word changed while stalled");

  // one sample in flight
  a_one_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("sample taken while another is being worked on");

  // a fresh drive word cannot follow a sample in the very next cycle
  a_no_early_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("drive word appeared too early");

endmodule

bind pid_controller_bandlimited_derivative_unit pidbd_checker u_pidbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .drive_i     (out_o.drive)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the band-limited derivative PID unit. Samples are
// streamed through the valid/ready input channel from a queue, each accepted
// sample is run through a Q16.16 predictor of the controller, and drive words
// leaving the unit are compared in order. Directed corner samples come first,
// then random phases under changing register settings and handshake pressure.
// ----------------------------------------------------------------------------
module tb
  import pidbd_pkg::*;
;

  localparam longint S32Hi      = 64'sd2147483647;
  localparam longint S32Lo      = -64'sd2147483648;
  localparam int     CycleLimit = 2000000;
  localparam int     HoldCycles = 3000;

  typedef struct packed {
    logic signed [DataW-1:0]   tgt;
    logic signed [DataW-1:0]   meas;
    logic        [PeriodW-1:0] period;
  } sample_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_we   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx  = '0;
  logic [DataW-1:0]   cfg_data = '0;

  logic                      drv_valid  = 1'b0;
  logic signed [DataW-1:0]   drv_tgt    = '0;
  logic signed [DataW-1:0]   drv_meas   = '0;
  logic        [PeriodW-1:0] drv_period = '0;
  logic                      mon_ready  = 1'b0;

  pidbd_in_if  in_if ();
  pidbd_out_if out_if ();

  assign in_if.valid     = drv_valid;
  assign in_if.sp_angle  = drv_tgt;
  assign in_if.fb_angle  = drv_meas;
  assign in_if.period_ms = drv_period;
  assign out_if.ready    = mon_ready;

  pid_controller_bandlimited_derivative_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  sample_t                 pending_samples[$];
  logic signed [DataW-1:0] drive_expected[$];

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  logic        hold_go   = 1'b0;
  logic        rx_hold   = 1'b0;
  int          err_count = 0;
  int          cycle_count = 0;

  // register shadow and controller state, all as wide signed integers
  longint cfg_shadow [8];
  longint integ_acc  = 0;
  longint prev_err   = 0;
  longint deriv_acc  = 0;
  longint prev_meas  = 0;

  int track_tgt  = 0;
  int track_meas = 0;

  function automatic longint sat32(longint x);
    if (x > S32Hi) return S32Hi;
    if (x < S32Lo) return S32Lo;
    return x;
  endfunction

  // divide by 2^sh, rounding to nearest with ties away from zero
  function automatic longint round_shift(longint p, int sh);
    longint m;
    m = (p < 0) ? -p : p;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return (p < 0) ? -m : m;
  endfunction

  function automatic longint qmul(longint x, longint y);
    return sat32(round_shift(x * y, 16));
  endfunction

  function automatic longint qdiv(longint num, longint den);
    longint m;
    m = (num < 0) ? -num : num;
    m = (m * 65536 + den / 2) / den;
    return sat32((num < 0) ? -m : m);
  endfunction

  function automatic longint limit(longint x, longint lo, longint hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic logic signed [DataW-1:0] predict_drive(sample_t s);
    longint t, e, p, k, es, integ, dm, a, c, b, den, num, d, y;
    t     = (longint'(s.period) * 65536 + 500) / 1000;
    e     = sat32(longint'(s.tgt) - longint'(s.meas));
    p     = qmul(cfg_shadow[CFG_GAIN_P], e);
    k     = qmul(cfg_shadow[CFG_GAIN_I], t);
    es    = sat32(e + prev_err);
    integ = sat32(integ_acc + sat32(round_shift(k * es, 17)));
    integ = limit(integ, cfg_shadow[CFG_INTEG_MIN], cfg_shadow[CFG_INTEG_MAX]);
    dm    = sat32(longint'(s.meas) - prev_meas);
    a     = sat32(round_shift(cfg_shadow[CFG_GAIN_D] * dm, 15));
    c     = sat32(2 * cfg_shadow[CFG_FILTER_TAU] - t);
    b     = qmul(c, deriv_acc);
    den   = sat32(2 * cfg_shadow[CFG_FILTER_TAU] + t);
    num   = sat32(b - a);
    // filter holds its value when 2*tau+T is zero
    d     = (den > 0) ? qdiv(num, den) : deriv_acc;
    y     = sat32(p + integ + d);
    y     = limit(y, cfg_shadow[CFG_OUT_MIN], cfg_shadow[CFG_OUT_MAX]);
    integ_acc = integ;
    deriv_acc = d;
    prev_err  = e;
    prev_meas = s.meas;
    return y[DataW-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [DataW-1:0] got,
                                 logic [DataW-1:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    err_count++;
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready) begin
        drive_expected.push_back(predict_drive('{drv_tgt, drv_meas, drv_period}));
      end
      if (!drv_valid || in_if.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
          sample_t s;
          s = pending_samples.pop_front();
          drv_valid  <= 1'b1;
          drv_tgt    <= s.tgt;
          drv_meas   <= s.meas;
          drv_period <= s.period;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mon_ready <= 1'b0;
    end else begin
      if (out_if.valid && mon_ready) begin
        if (drive_expected.size() == 0) begin
          report_mismatch("unexpected drive word", out_if.drive, '0);
        end else begin
          logic signed [DataW-1:0] want;
          want = drive_expected.pop_front();
          if (out_if.drive !== want) report_mismatch("drive", out_if.drive, want);
        end
      end
      mon_ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off so the unit backs up onto its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               drive_expected.size());
      $display("** pid_controller_bandlimited_derivative_unit: FAILED **");
      $finish;
    end
  end

  task automatic cfg_write(cfg_idx_e idx, logic [DataW-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == CFG_FILTER_TAU) cfg_shadow[idx] = longint'(val[TauW-1:0]);
    else cfg_shadow[idx] = longint'($signed(val));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DataW-1:0] pick_extreme();
    case ($urandom_range(4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // style 0 plausible loop tuning, 1 fully random, 2 extreme values
  task automatic cfg_random(int style);
    logic [DataW-1:0] v [8];
    case (style)
      0: begin
        v[CFG_GAIN_P]     = $urandom_range(524288) - 262144;
        v[CFG_GAIN_I]     = $urandom_range(1048576) - 524288;
        v[CFG_GAIN_D]     = $urandom_range(262144) - 131072;
        v[CFG_FILTER_TAU] = $urandom_range(6554);
        v[CFG_OUT_MIN]    = -$urandom_range(3276800);
        v[CFG_OUT_MAX]    = $urandom_range(3276800);
        v[CFG_INTEG_MIN]  = -$urandom_range(655360);
        v[CFG_INTEG_MAX]  = $urandom_range(655360);
      end
      1: begin
        foreach (v[i]) v[i] = $urandom;
      end
      default: begin
        foreach (v[i]) v[i] = pick_extreme();
        v[CFG_FILTER_TAU] = ($urandom_range(1) == 0) ? 32'h7fff_ffff : $urandom_range(1);
      end
    endcase
    cfg_write(CFG_GAIN_P, v[CFG_GAIN_P]);
    cfg_write(CFG_GAIN_I, v[CFG_GAIN_I]);
    cfg_write(CFG_GAIN_D, v[CFG_GAIN_D]);
    cfg_write(CFG_FILTER_TAU, v[CFG_FILTER_TAU]);
    cfg_write(CFG_OUT_MIN, v[CFG_OUT_MIN]);
    cfg_write(CFG_OUT_MAX, v[CFG_OUT_MAX]);
    cfg_write(CFG_INTEG_MIN, v[CFG_INTEG_MIN]);
    cfg_write(CFG_INTEG_MAX, v[CFG_INTEG_MAX]);
  endtask

  task automatic push_sample(logic [DataW-1:0] tgt, logic [DataW-1:0] meas,
                             logic [PeriodW-1:0] period);
    pending_samples.push_back('{tgt, meas, period});
  endtask

  // mostly a tracking loop with noise, some zero periods and raw random words
  function automatic sample_t make_sample();
    sample_t     s;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) begin
      s.tgt    = $urandom;
      s.meas   = $urandom;
      s.period = PeriodW'($urandom);
    end else begin
      if ($urandom_range(9) == 0) track_tgt = int'($urandom_range(11796480)) - 5898240;
      track_meas = track_meas + ((track_tgt - track_meas) >>> 3)
                   + int'($urandom_range(131072)) - 65536;
      s.tgt    = track_tgt;
      s.meas   = track_meas;
      s.period = (r < 28) ? 16'd0 : PeriodW'($urandom_range(40, 1));
    end
    return s;
  endfunction

  // checked away from the clock edge so the driver's updates have settled
  task automatic wait_idle();
    while (pending_samples.size() != 0 || drv_valid || drive_expected.size() != 0)
      @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic run_phase(int n, int in_idle, int out_stall, bit with_hold);
    idle_pct  = in_idle;
    stall_pct = out_stall;
    for (int i = 0; i < n; i++) pending_samples.push_back(make_sample());
    if (with_hold) begin
      while (pending_samples.size() > n - 10) @(posedge clk_i);
      hold_go <= 1'b1;
    end
    wait_idle();
  endtask

  initial begin
    cfg_shadow[CFG_GAIN_P]     = longint'(GainPRst);
    cfg_shadow[CFG_GAIN_I]     = longint'(GainIRst);
    cfg_shadow[CFG_GAIN_D]     = longint'(GainDRst);
    cfg_shadow[CFG_FILTER_TAU] = longint'(TauRst);
    cfg_shadow[CFG_OUT_MIN]    = longint'(OutMinRst);
    cfg_shadow[CFG_OUT_MAX]    = longint'(OutMaxRst);
    cfg_shadow[CFG_INTEG_MIN]  = longint'(IntegMinRst);
    cfg_shadow[CFG_INTEG_MAX]  = longint'(IntegMaxRst);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: field extremes and plain steps
    push_sample(32'h0, 32'h0, 16'd0);
    push_sample(32'h7fff_ffff, 32'h8000_0000, 16'hffff);
    push_sample(32'h8000_0000, 32'h7fff_ffff, 16'hffff);
    push_sample(32'h7fff_ffff, 32'h7fff_ffff, 16'd1);
    push_sample(32'h8000_0000, 32'h8000_0000, 16'd1);
    push_sample(32'd5898240, 32'd0, 16'd10);
    push_sample(32'd0, 32'd5898240, 16'd10);
    push_sample(32'd0, 32'd0, 16'd500);
    wait_idle();

    // zero time constant with zero period, crossed limits on both clamps
    cfg_write(CFG_FILTER_TAU, 32'd0);
    cfg_write(CFG_GAIN_P, 32'h7fff_ffff);
    cfg_write(CFG_GAIN_I, 32'h8000_0000);
    cfg_write(CFG_GAIN_D, 32'h7fff_ffff);
    cfg_write(CFG_OUT_MIN, 32'd1000);
    cfg_write(CFG_OUT_MAX, -32'd1000);
    cfg_write(CFG_INTEG_MIN, 32'd5);
    cfg_write(CFG_INTEG_MAX, -32'd5);
    push_sample(32'd0, 32'd0, 16'd0);
    push_sample(32'd1000, 32'd0, 16'd0);
    push_sample(32'h7fff_ffff, 32'h8000_0000, 16'd0);
    push_sample(32'h8000_0000, 32'h7fff_ffff, 16'hffff);
    push_sample(32'd12345, -32'd54321, 16'd7);
    push_sample(-32'd1, 32'd1, 16'd0);
    wait_idle();

    // widest limits, most negative gains, longest time constant
    cfg_write(CFG_GAIN_P, 32'h8000_0000);
    cfg_write(CFG_GAIN_I, 32'h8000_0000);
    cfg_write(CFG_GAIN_D, 32'h8000_0000);
    cfg_write(CFG_FILTER_TAU, 32'h7fff_ffff);
    cfg_write(CFG_OUT_MIN, 32'h8000_0000);
    cfg_write(CFG_OUT_MAX, 32'h7fff_ffff);
    cfg_write(CFG_INTEG_MIN, 32'h8000_0000);
    cfg_write(CFG_INTEG_MAX, 32'h7fff_ffff);
    push_sample(32'h7fff_ffff, 32'h8000_0000, 16'hffff);
    push_sample(32'h8000_0000, 32'h7fff_ffff, 16'hffff);
    push_sample(32'd0, 32'h7fff_ffff, 16'd0);
    push_sample(32'd0, 32'h8000_0000, 16'd1);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      cfg_random((ph == 0) ? 0 : ph % 3);
      case (ph % 4)
        0: run_phase(165, 0, 0, ph == 0);
        1: run_phase(165, 79, 0, 1'b0);
        2: run_phase(165, 0, 79, 1'b0);
        default: run_phase(165, 11, 11, 1'b0);
      endcase
    end

    wait_idle();
    repeat (400) @(posedge clk_i);
    if (drive_expected.size() != 0)
      report_mismatch("drive words never arrived", drive_expected.size(), '0);
    if (err_count == 0) begin
      $display("** pid_controller_bandlimited_derivative_unit: PASSED **");
    end else begin
      $display("** pid_controller_bandlimited_derivative_unit: FAILED **");
    end
    $finish;
  end

endmodule
